[rtl/lpcp_pkg.sv]
// ----------------------------------------------------------------------------
// Closest points between two 3D lines: shared types and constants
// Status codes of a result beat and the limb size used to split wide products.
// ----------------------------------------------------------------------------
`default_nettype none

package lpcp_pkg;

  // Wide operands are cut into limbs of this many bits; only the top limb is signed.
  localparam int LIMB_BITS = 32;

  typedef enum logic [1:0] {
    ST_SKEW     = 2'd0,
    ST_PARALLEL = 2'd1,
    ST_DEGEN    = 2'd2,
    ST_SAT      = 2'd3
  } status_e;

endpackage

`default_nettype wire

[rtl/line_pair_closest_points.sv]
// ----------------------------------------------------------------------------
// Closest points between two 3D lines
// Pipelined exact solver: cross products, wide dot products, a truncating
// restoring divider per output coordinate, then add and saturate.
// ----------------------------------------------------------------------------
//
//  Channel  | Direction | tdata (low bits first)                        | tuser
//  ---------+-----------+-----------------------------------------------+-------
//  s_axis   | in        | c1 x,y,z, d1 x,y,z, c2 x,y,z, d2 x,y,z        | -
//  m_axis   | out       | near_first x,y,z, near_second x,y,z           | status
//
//  One beat enters per cycle while the skid register is empty. The path holds
//  COORD_WIDTH + 10 register stages: nine stages of multiply, add and
//  magnitude, one stage per quotient bit, and the output stage.
//  Reset clears the valid bits of all stages and the output skid register.
//  A stalled output first parks its result in the skid register; only then
//  does the whole pipeline hold, so an input beat is taken while a result waits.
//
`default_nettype none

module line_pair_closest_points #(
  parameter int COORD_WIDTH = 32
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   s_axis_tvalid,
  output      logic                                   s_axis_tready,
  // first_center_x/y/z, first_dir_x/y/z, second_center_x/y/z, second_dir_x/y/z
  input  wire logic [((12*COORD_WIDTH+7)/8)*8-1:0]    s_axis_tdata,
  output      logic                                   m_axis_tvalid,
  input  wire logic                                   m_axis_tready,
  // near_first_x/y/z, near_second_x/y/z
  output      logic [((6*COORD_WIDTH+7)/8)*8-1:0]     m_axis_tdata,
  // status
  output      logic [1:0]                             m_axis_tuser
);

  localparam int W    = COORD_WIDTH;
  localparam int LB   = lpcp_pkg::LIMB_BITS;
  localparam int WW   = W + 1;
  localparam int PDW  = 2 * W + 1;
  localparam int DDW  = 2 * W;
  localparam int NW   = 2 * W + 1;
  localparam int AW   = 2 * W + 2;
  localparam int D2W  = 2 * W + 2;
  localparam int PNW  = 2 * W + 3;
  localparam int K4   = (AW + LB - 1) / LB;
  localparam int PPW  = 2 * LB + 2;
  localparam int PRW  = 2 * AW;
  localparam int NUMW = 2 * AW + 2;
  localparam int KX   = (NUMW + LB - 1) / LB;
  localparam int KY   = (W + LB - 1) / LB;
  localparam int EXW  = KX * LB;
  localparam int PW   = NUMW + W;
  localparam int RW   = PW;
  localparam int NST  = 10 + W;
  localparam int OTW  = ((6 * W + 7) / 8) * 8;
  localparam int SMW  = W + 2;

  localparam logic signed [W+1:0] MAXV = {3'b000, {(W-1){1'b1}}};
  localparam logic signed [W+1:0] MINV = {3'b111, {(W-1){1'b0}}};

  typedef struct packed {
    logic [2:0][W-1:0] c1;
    logic [2:0][W-1:0] d1;
    logic [2:0][W-1:0] c2;
    logic [2:0][W-1:0] d2;
    logic [D2W-1:0]    den2;
    logic [PNW-1:0]    pnum;
    logic [NUMW-1:0]   den;
    logic              par;
    logic              degen;
  } ctx_t;

  // Limb idx of a sign-extended word; only the top limb carries the sign.
  function automatic logic signed [LB:0] limb_of(input logic [EXW-1:0] v,
                                                 input int idx, input int top);
    logic sgn;
    sgn = (idx == top) ? v[idx*LB + LB - 1] : 1'b0;
    return {sgn, v[idx*LB +: LB]};
  endfunction

  // --------------------------------------------------------------------------
  // Flow control: every stage moves together unless the skid register is full.
  // --------------------------------------------------------------------------
  logic           ce;
  logic [NST-1:0] vld_q;
  logic           skid_vld_q;
  logic [OTW-1:0] skid_data_q;
  logic [1:0]     skid_user_q;
  logic [OTW-1:0] out_data_q;
  logic [1:0]     out_user_q;

  assign ce            = !skid_vld_q;
  assign s_axis_tready = ce;
  assign m_axis_tvalid = skid_vld_q || vld_q[NST-1];
  assign m_axis_tdata  = skid_vld_q ? skid_data_q : out_data_q;
  assign m_axis_tuser  = skid_vld_q ? skid_user_q : out_user_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q      <= '0;
      skid_vld_q <= 1'b0;
    end else begin
      if (ce) begin
        vld_q <= {vld_q[NST-2:0], s_axis_tvalid};
      end
      if (skid_vld_q) begin
        if (m_axis_tready) begin
          skid_vld_q <= 1'b0;
        end
      end else if (vld_q[NST-1] && !m_axis_tready) begin
        skid_vld_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!skid_vld_q && vld_q[NST-1] && !m_axis_tready) begin
      skid_data_q <= out_data_q;
      skid_user_q <= out_user_q;
    end
  end

  // --------------------------------------------------------------------------
  // Context that rides along with each beat.
  // --------------------------------------------------------------------------
  ctx_t ctx_d [NST-1];
  ctx_t ctx_q [NST-1];

  logic                   nz_d;
  logic signed [D2W-1:0]  den2_d;
  logic signed [PNW-1:0]  pnum_d;
  logic [NUMW-1:0]        den_d;
  logic                   degen_d;

  always_comb begin
    ctx_d[0] = '0;
    for (int k = 0; k < 3; k++) begin
      ctx_d[0].c1[k] = s_axis_tdata[k*W +: W];
      ctx_d[0].d1[k] = s_axis_tdata[(3+k)*W +: W];
      ctx_d[0].c2[k] = s_axis_tdata[(6+k)*W +: W];
      ctx_d[0].d2[k] = s_axis_tdata[(9+k)*W +: W];
    end
    for (int k = 1; k < NST - 1; k++) begin
      ctx_d[k] = ctx_q[k-1];
      if (k == 2) begin
        ctx_d[k].par  = nz_d;
        ctx_d[k].den2 = den2_d;
        ctx_d[k].pnum = pnum_d;
      end
      if (k == 5) begin
        ctx_d[k].den   = den_d;
        ctx_d[k].degen = degen_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce) begin
      for (int k = 0; k < NST - 1; k++) begin
        ctx_q[k] <= ctx_d[k];
      end
    end
  end

  // Stage 1: w = c2 - c1.
  logic signed [WW-1:0] w_d [3];
  logic signed [WW-1:0] w_q [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      w_d[k] = WW'($signed(ctx_d[0].c2[k])) - WW'($signed(ctx_d[0].c1[k]));
    end
  end

  // Stage 2: all coordinate products.
  logic signed [PDW-1:0] wd1_d [3][3];
  logic signed [PDW-1:0] wd1_q [3][3];
  logic signed [PDW-1:0] wd2_d [3][3];
  logic signed [PDW-1:0] wd2_q [3][3];
  logic signed [DDW-1:0] dd_d  [3][3];
  logic signed [DDW-1:0] dd_q  [3][3];
  logic signed [DDW-1:0] dsq_d [3];
  logic signed [DDW-1:0] dsq_q [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        wd1_d[i][j] = PDW'(w_q[i]) * PDW'($signed(ctx_q[0].d1[j]));
        wd2_d[i][j] = PDW'(w_q[i]) * PDW'($signed(ctx_q[0].d2[j]));
        dd_d[i][j]  = DDW'($signed(ctx_q[0].d1[i])) * DDW'($signed(ctx_q[0].d2[j]));
      end
      dsq_d[i] = DDW'($signed(ctx_q[0].d2[i])) * DDW'($signed(ctx_q[0].d2[i]));
    end
  end

  // Stage 3: n = d1 x d2, a = w x d2, b = w x d1, and the parallel-case terms.
  logic signed [NW-1:0] n_d [3];
  logic signed [NW-1:0] n_q [3];
  logic signed [AW-1:0] a_d [3];
  logic signed [AW-1:0] a_q [3];
  logic signed [AW-1:0] b_d [3];
  logic signed [AW-1:0] b_q [3];

  always_comb begin
    n_d[0] = NW'(dd_q[1][2]) - NW'(dd_q[2][1]);
    n_d[1] = NW'(dd_q[2][0]) - NW'(dd_q[0][2]);
    n_d[2] = NW'(dd_q[0][1]) - NW'(dd_q[1][0]);
    a_d[0] = AW'(wd2_q[1][2]) - AW'(wd2_q[2][1]);
    a_d[1] = AW'(wd2_q[2][0]) - AW'(wd2_q[0][2]);
    a_d[2] = AW'(wd2_q[0][1]) - AW'(wd2_q[1][0]);
    b_d[0] = AW'(wd1_q[1][2]) - AW'(wd1_q[2][1]);
    b_d[1] = AW'(wd1_q[2][0]) - AW'(wd1_q[0][2]);
    b_d[2] = AW'(wd1_q[0][1]) - AW'(wd1_q[1][0]);
    nz_d   = (n_d[0] == '0) && (n_d[1] == '0) && (n_d[2] == '0);
    den2_d = D2W'(dsq_q[0]) + D2W'(dsq_q[1]) + D2W'(dsq_q[2]);
    // (c1 - c2).d2 is the negated w.d2.
    pnum_d = -(PNW'(wd2_q[0][0]) + PNW'(wd2_q[1][1]) + PNW'(wd2_q[2][2]));
  end

  // Stage 4: partial products of a.n, b.n and n.n.
  logic signed [PPW-1:0] pp4_d [3][3][K4][K4];
  logic signed [PPW-1:0] pp4_q [3][3][K4][K4];

  always_comb begin
    logic signed [EXW-1:0] xe;
    logic signed [EXW-1:0] ye;
    for (int t = 0; t < 3; t++) begin
      for (int k = 0; k < 3; k++) begin
        ye = EXW'(n_q[k]);
        case (t)
          0:       xe = EXW'(a_q[k]);
          1:       xe = EXW'(b_q[k]);
          default: xe = EXW'(n_q[k]);
        endcase
        for (int i = 0; i < K4; i++) begin
          for (int j = 0; j < K4; j++) begin
            pp4_d[t][k][i][j] = PPW'(limb_of(xe, i, K4 - 1)) *
                                PPW'(limb_of(ye, j, K4 - 1));
          end
        end
      end
    end
  end

  // Stage 5: recombine the nine wide products.
  logic signed [PRW-1:0] prd_d [3][3];
  logic signed [PRW-1:0] prd_q [3][3];

  always_comb begin
    logic signed [PRW-1:0] ext;
    for (int t = 0; t < 3; t++) begin
      for (int k = 0; k < 3; k++) begin
        prd_d[t][k] = '0;
        for (int i = 0; i < K4; i++) begin
          for (int j = 0; j < K4; j++) begin
            ext         = PRW'(pp4_q[t][k][i][j]);
            prd_d[t][k] = prd_d[t][k] + (ext <<< (LB * (i + j)));
          end
        end
      end
    end
  end

  // Stage 6: finish the dot products and choose skew or parallel operands.
  logic signed [NUMW-1:0] num1_d, num1_q;
  logic signed [NUMW-1:0] num2_d, num2_q;

  always_comb begin
    logic signed [NUMW-1:0] dan;
    logic signed [NUMW-1:0] dbn;
    logic signed [NUMW-1:0] dnn;
    dan = NUMW'(prd_q[0][0]) + NUMW'(prd_q[0][1]) + NUMW'(prd_q[0][2]);
    dbn = NUMW'(prd_q[1][0]) + NUMW'(prd_q[1][1]) + NUMW'(prd_q[1][2]);
    dnn = NUMW'(prd_q[2][0]) + NUMW'(prd_q[2][1]) + NUMW'(prd_q[2][2]);
    if (ctx_q[4].par) begin
      num1_d = '0;
      num2_d = NUMW'($signed(ctx_q[4].pnum));
      den_d  = {{(NUMW-D2W){1'b0}}, ctx_q[4].den2};
    end else begin
      num1_d = dan;
      num2_d = dbn;
      den_d  = dnn;
    end
    degen_d = ctx_q[4].par && (ctx_q[4].den2 == '0);
  end

  // Stage 7: partial products of numerator times direction, one per output.
  logic signed [PPW-1:0] pp7_d [6][KX][KY];
  logic signed [PPW-1:0] pp7_q [6][KX][KY];

  always_comb begin
    logic signed [EXW-1:0] xe;
    logic signed [EXW-1:0] ye;
    for (int l = 0; l < 6; l++) begin
      if (l < 3) begin
        xe = EXW'(num1_q);
        ye = EXW'($signed(ctx_q[5].d1[l % 3]));
      end else begin
        xe = EXW'(num2_q);
        ye = EXW'($signed(ctx_q[5].d2[l % 3]));
      end
      for (int i = 0; i < KX; i++) begin
        for (int j = 0; j < KY; j++) begin
          pp7_d[l][i][j] = PPW'(limb_of(xe, i, KX - 1)) * PPW'(limb_of(ye, j, KY - 1));
        end
      end
    end
  end

  // Stage 8: dividends.
  logic signed [PW-1:0] nv_d [6];
  logic signed [PW-1:0] nv_q [6];

  always_comb begin
    logic signed [PW-1:0] ext;
    for (int l = 0; l < 6; l++) begin
      nv_d[l] = '0;
      for (int i = 0; i < KX; i++) begin
        for (int j = 0; j < KY; j++) begin
          ext     = PW'(pp7_q[l][i][j]);
          nv_d[l] = nv_d[l] + (ext <<< (LB * (i + j)));
        end
      end
    end
  end

  // Stage 9 and on: magnitude division, one quotient bit per stage.
  // A quotient of 2^W or more always saturates, so only W bits are formed.
  logic [RW-1:0] rem_q [W+1][6];
  logic [W-1:0]  quo_q [W+1][6];
  logic [5:0]    neg_q [W+1];
  logic [5:0]    big_q [W+1];

  always_ff @(posedge clk_i) begin
    if (ce) begin
      for (int l = 0; l < 6; l++) begin
        neg_q[0][l] <= nv_q[l][PW-1];
        rem_q[0][l] <= nv_q[l][PW-1] ? RW'(-nv_q[l]) : RW'(nv_q[l]);
        big_q[0][l] <= (nv_q[l][PW-1] ? RW'(-nv_q[l]) : RW'(nv_q[l]))
                       >= ({{(RW-NUMW){1'b0}}, ctx_q[7].den} << W);
        quo_q[0][l] <= '0;
      end
    end
  end

  for (genvar j = 0; j < W; j++) begin : g_div
    localparam int BI = W - 1 - j;
    logic [RW-1:0] dsh;
    logic [RW-1:0] rem_d [6];
    logic [W-1:0]  quo_d [6];

    always_comb begin
      dsh = {{(RW-NUMW){1'b0}}, ctx_q[8+j].den} << BI;
      for (int l = 0; l < 6; l++) begin
        rem_d[l] = rem_q[j][l];
        quo_d[l] = quo_q[j][l];
        if (rem_q[j][l] >= dsh) begin
          rem_d[l]     = rem_q[j][l] - dsh;
          quo_d[l][BI] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (ce) begin
        for (int l = 0; l < 6; l++) begin
          rem_q[j+1][l] <= rem_d[l];
          quo_q[j+1][l] <= quo_d[l];
        end
        neg_q[j+1] <= neg_q[j];
        big_q[j+1] <= big_q[j];
      end
    end
  end

  // Output stage: add the base point, saturate, and set status.
  logic [OTW-1:0] out_data_d;
  logic [1:0]     out_user_d;

  always_comb begin
    logic signed [W:0]   qs;
    logic signed [W+1:0] sum;
    logic signed [W-1:0] base;
    logic [W-1:0]        res;
    logic                sat;
    lpcp_pkg::status_e   st;
    ctx_t                cx;
    cx         = ctx_q[NST-2];
    sat        = 1'b0;
    out_data_d = '0;
    for (int l = 0; l < 6; l++) begin
      base = (l < 3) ? $signed(cx.c1[l % 3]) : $signed(cx.c2[l % 3]);
      qs   = neg_q[W][l] ? -$signed({1'b0, quo_q[W][l]}) : $signed({1'b0, quo_q[W][l]});
      sum  = SMW'(base) + SMW'(qs);
      res  = sum[W-1:0];
      if (big_q[W][l]) begin
        sat = 1'b1;
        res = neg_q[W][l] ? MINV[W-1:0] : MAXV[W-1:0];
      end else if (sum > MAXV) begin
        sat = 1'b1;
        res = MAXV[W-1:0];
      end else if (sum < MINV) begin
        sat = 1'b1;
        res = MINV[W-1:0];
      end
      if (cx.degen) begin
        res = base;
      end
      out_data_d[l*W +: W] = res;
    end
    if (cx.degen) begin
      st = lpcp_pkg::ST_DEGEN;
    end else if (sat) begin
      st = lpcp_pkg::ST_SAT;
    end else if (cx.par) begin
      st = lpcp_pkg::ST_PARALLEL;
    end else begin
      st = lpcp_pkg::ST_SKEW;
    end
    out_user_d = st;
  end

  always_ff @(posedge clk_i) begin
    if (ce) begin
      w_q    <= w_d;
      wd1_q  <= wd1_d;
      wd2_q  <= wd2_d;
      dd_q   <= dd_d;
      dsq_q  <= dsq_d;
      n_q    <= n_d;
      a_q    <= a_d;
      b_q    <= b_d;
      pp4_q  <= pp4_d;
      prd_q  <= prd_d;
      num1_q <= num1_d;
      num2_q <= num2_d;
      pp7_q  <= pp7_d;
      nv_q   <= nv_d;
      out_data_q <= out_data_d;
      out_user_q <= out_user_d;
    end
  end

endmodule

`default_nettype wire
